FILE: design/emgr_pkg.sv
// shared types, constants and helpers of the emg moving-rms click detector
// no dependencies; imported by every module of the block but emgr_ram
package emgr_pkg;

  localparam int WINDOW_DEF = 60;   // samples in the rms window
  localparam int ADC_W      = 12;
  localparam int SMP_W      = 13;   // centred sample, signed
  localparam int SQ_W       = 24;   // square of a centred sample
  localparam int SUM_W      = 32;
  localparam int BOUND_W    = 33;   // threshold^2 * window, window up to 256
  localparam int FIFO_DEPTH = 8;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [ADC_W-1:0] ZERO_OFFSET_RST = 12'd1800;
  localparam logic [ADC_W-1:0] RMS_LOW_RST     = 12'd70;
  localparam logic [ADC_W-1:0] RMS_HIGH_RST    = 12'd500;

  // register indexes, byte address is 4 * index
  typedef enum logic [1:0] {
    REG_ZERO_OFFSET = 2'd0,
    REG_RMS_LOW     = 2'd1,
    REG_RMS_HIGH    = 2'd2,
    REG_NONE        = 2'd3
  } reg_idx_t;

  typedef logic signed [SMP_W-1:0] smp_t;

  typedef struct packed {
    logic [ADC_W-1:0]   zero_offset;
    logic [BOUND_W-1:0] lo_bound;
    logic [BOUND_W-1:0] hi_bound;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             click;
  } res_t;

  // square of a centred sample; its magnitude never exceeds 4095
  function automatic logic [SQ_W-1:0] square_of(smp_t v);
    logic [SMP_W-1:0] mag;
    mag = v[SMP_W-1] ? SMP_W'(-v) : SMP_W'(v);
    return SQ_W'(mag[ADC_W-1:0]) * SQ_W'(mag[ADC_W-1:0]);
  endfunction

endpackage

FILE: design/emg_moving_rms_click_detector.sv
// top level of the emg moving-rms click detector
// depends on emgr_pkg, emgr_cfg, emgr_energy, emgr_ram and emgr_fifo
//
// usage:
//   in_* stream: one raw 12-bit adc sample per item, in_tdata[11:0]
//   out_* stream: one result per item, out_tdata[0] click flag,
//     out_tdata[32:1] sum of squares of the centred window samples
//   cfg_* apb port: zero_offset at 0x0, rms_low at 0x4, rms_high at 0x8
// throughput: one item per cycle while the receiver takes results; the window
//   ram takes one read of the oldest sample and one write of the newest in the
//   same cycle; an item passes the ram read on the accepting edge, squaring,
//   sum update and result fifo before its result shows on out_tvalid
// a threshold write passes the square and bound registers to the compare bounds
// reset (synchronous, rst_n low): registers return to 1800 / 70 / 500, the
//   running sum and write pointer clear, the window reads as all zero until
//   it has been filled once; no clearing pass, items are taken right away
// receiver stall: results queue in an 8-entry fifo; in_tready drops once
//   8 items are accepted but not yet delivered, so nothing is lost
module emg_moving_rms_click_detector import emgr_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,    // [11:0] adc_sample
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [39:0]           out_tdata,   // [0] click, [32:1] sum_of_squares
  // configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int PEND_W = $clog2(FIFO_DEPTH + 1);

  cfg_t              cfg;
  logic              in_fire, out_fire;
  logic              res_valid;
  res_t              res, out_res;
  logic [PEND_W-1:0] pend_r, pend_nxt;

  emgr_cfg #(.WINDOW(WINDOW)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // credit scheme: items in the pipeline plus fifo never exceed fifo depth
  assign in_tready = (pend_r < PEND_W'(FIFO_DEPTH));
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_fire && !out_fire) begin
      pend_nxt = pend_r + PEND_W'(1);
    end else if (out_fire && !in_fire) begin
      pend_nxt = pend_r - PEND_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  emgr_energy #(.WINDOW(WINDOW)) u_energy (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_sample (in_tdata[ADC_W-1:0]),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  emgr_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (res_valid),
    .wr_data  (res),
    .rd_en    (out_tready),
    .rd_valid (out_tvalid),
    .rd_data  (out_res)
  );

  // pad to whole bytes
  assign out_tdata = {7'b0, out_res.sum, out_res.click};

endmodule

FILE: design/emgr_ram.sv
// generic single-clock ram, one write port and one registered read port
// read-first when both ports hit the same address; no dependencies
module emgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

FILE: design/emgr_cfg.sv
// apb register file of the detector and precomputed rms threshold bounds
// depends on emgr_pkg
module emgr_cfg import emgr_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [ADC_W-1:0]   zero_offset_r, rms_low_r, rms_high_r;
  logic [SQ_W-1:0]    lo_sq_r, hi_sq_r;
  logic [BOUND_W-1:0] lo_bound_r, hi_bound_r;
  reg_idx_t           idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_offset_r <= ZERO_OFFSET_RST;
      rms_low_r     <= RMS_LOW_RST;
      rms_high_r    <= RMS_HIGH_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_ZERO_OFFSET: zero_offset_r <= pwdata[ADC_W-1:0];
        REG_RMS_LOW:     rms_low_r     <= pwdata[ADC_W-1:0];
        REG_RMS_HIGH:    rms_high_r    <= pwdata[ADC_W-1:0];
        default: ;
      endcase
    end
  end

  // squares then times window, one multiply per stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_sq_r    <= SQ_W'(RMS_LOW_RST) * SQ_W'(RMS_LOW_RST);
      hi_sq_r    <= SQ_W'(RMS_HIGH_RST) * SQ_W'(RMS_HIGH_RST);
      lo_bound_r <= BOUND_W'(RMS_LOW_RST) * BOUND_W'(RMS_LOW_RST) * BOUND_W'(WINDOW);
      hi_bound_r <= BOUND_W'(RMS_HIGH_RST) * BOUND_W'(RMS_HIGH_RST) * BOUND_W'(WINDOW);
    end else begin
      lo_sq_r    <= SQ_W'(rms_low_r) * SQ_W'(rms_low_r);
      hi_sq_r    <= SQ_W'(rms_high_r) * SQ_W'(rms_high_r);
      lo_bound_r <= BOUND_W'(lo_sq_r) * BOUND_W'(WINDOW);
      hi_bound_r <= BOUND_W'(hi_sq_r) * BOUND_W'(WINDOW);
    end
  end

  always_comb begin
    unique case (idx)
      REG_ZERO_OFFSET: prdata = CFG_DATA_W'(zero_offset_r);
      REG_RMS_LOW:     prdata = CFG_DATA_W'(rms_low_r);
      REG_RMS_HIGH:    prdata = CFG_DATA_W'(rms_high_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg.zero_offset = zero_offset_r;
  assign cfg.lo_bound    = lo_bound_r;
  assign cfg.hi_bound    = hi_bound_r;

endmodule

FILE: design/emgr_energy.sv
// window store, running sum of squares and threshold compare, one item per cycle
// depends on emgr_pkg and emgr_ram
module emgr_energy import emgr_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic [ADC_W-1:0] in_sample,
  input  cfg_t             cfg,
  output logic             res_valid,
  output res_t             res
);

  localparam int PTR_W = $clog2(WINDOW);

  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic             full_r, full_nxt;
  smp_t             centred;
  logic [SMP_W-1:0] ram_rdata;

  logic             v1_r, full1_r;
  smp_t             new1_r;
  smp_t             old1;

  logic             v2_r;
  logic [SQ_W-1:0]  new_sq_r, old_sq_r;

  logic             v3_r;
  logic [SUM_W-1:0] sum_r, sum_nxt;

  assign centred = smp_t'({1'b0, in_sample} - {1'b0, cfg.zero_offset});

  // the slot read is the one being overwritten; the ram returns its old value
  emgr_ram #(.WIDTH(SMP_W), .DEPTH(WINDOW)) u_window (
    .clk   (clk),
    .we    (in_fire),
    .waddr (ptr_r),
    .wdata (centred),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    ptr_nxt  = ptr_r;
    full_nxt = full_r;
    if (in_fire) begin
      if (ptr_r == PTR_W'(WINDOW - 1)) begin
        ptr_nxt  = '0;
        full_nxt = 1'b1;
      end else begin
        ptr_nxt = ptr_r + PTR_W'(1);
      end
    end
  end

  // until the first wrap every slot read was never written and counts as zero
  assign old1    = full1_r ? smp_t'(ram_rdata) : '0;
  assign sum_nxt = v2_r ? (sum_r + SUM_W'(new_sq_r) - SUM_W'(old_sq_r)) : sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      full_r <= 1'b0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      sum_r  <= '0;
    end else begin
      ptr_r  <= ptr_nxt;
      full_r <= full_nxt;
      v1_r   <= in_fire;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      sum_r  <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    new1_r   <= centred;
    full1_r  <= full_r;
    new_sq_r <= square_of(new1_r);
    old_sq_r <= square_of(old1);
  end

  assign res_valid = v3_r;
  assign res.sum   = sum_r;
  assign res.click = ({1'b0, sum_r} > cfg.lo_bound) && ({1'b0, sum_r} < cfg.hi_bound);

endmodule

FILE: design/emgr_fifo.sv
// small register fifo holding finished results until the receiver takes them
// depends on emgr_pkg
module emgr_fifo import emgr_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  res_t wr_data,
  input  logic rd_en,
  output logic rd_valid,
  output res_t rd_data
);

  localparam int AW = $clog2(DEPTH);

  res_t          mem [DEPTH];
  logic [AW:0]   wr_ptr_r, rd_ptr_r;

  assign rd_valid = (wr_ptr_r != rd_ptr_r);
  assign rd_data  = mem[rd_ptr_r[AW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + (AW+1)'(1);
      end
      if (rd_en && rd_valid) begin
        rd_ptr_r <= rd_ptr_r + (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r[AW-1:0]] <= wr_data;
    end
  end

endmodule
